// File: hdl/mtpc_pkg.sv
// ---------------------------------------------------------------------------
// mtpc_pkg
// Shared types and constants of the mesh threshold point compactor.
// ---------------------------------------------------------------------------
package mtpc_pkg;

    localparam int PID_W      = 16;
    localparam int ID_SPACE   = 65536;
    localparam int THR_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ERR_W      = 2;
    localparam int MAP_W      = PID_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_LOWER     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ON_CELLS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALL_CORN  = 3'd4;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_REVERSED = 2'd1;
    localparam logic [ERR_W-1:0] ERR_CORNERS  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_MAP_FULL = 2'd3;

    localparam logic OP_CORNER   = 1'b0;
    localparam logic OP_NEW_MESH = 1'b1;

    localparam logic [1:0] BND_OPEN   = 2'd0;
    localparam logic [1:0] BND_LOWER  = 2'd1;
    localparam logic [1:0] BND_UPPER  = 2'd2;
    localparam logic [1:0] BND_CLOSED = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BUF,
        ST_MAP,
        ST_UPD
    } state_t;

    typedef struct packed {
        logic clear_en;
        logic accept_en;
        logic buf_rd;
        logic map_rd;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic clear_req;
        logic go_emit;
        logic out_free;
        logic emit_last;
    } stat_t;

endpackage

// File: hdl/mtpc_ram.sv
// ---------------------------------------------------------------------------
// mtpc_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module mtpc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/mtpc_ctrl.sv
// ---------------------------------------------------------------------------
// mtpc_ctrl
// Controller: map clearing sweep, request intake and per-corner emit steps.
// ---------------------------------------------------------------------------
module mtpc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  mtpc_pkg::stat_t st,
    output mtpc_pkg::cmd_t  cmd
);

    mtpc_pkg::state_t state_reg;
    mtpc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtpc_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mtpc_pkg::ST_CLEAR:
            begin
                if (st.clr_done)
                begin
                    state_next = mtpc_pkg::ST_IDLE;
                end
            end
            mtpc_pkg::ST_IDLE:
            begin
                if (st.clear_req)
                begin
                    state_next = mtpc_pkg::ST_CLEAR;
                end
                else if (st.go_emit)
                begin
                    state_next = mtpc_pkg::ST_BUF;
                end
            end
            mtpc_pkg::ST_BUF:
            begin
                state_next = mtpc_pkg::ST_MAP;
            end
            mtpc_pkg::ST_MAP:
            begin
                state_next = mtpc_pkg::ST_UPD;
            end
            mtpc_pkg::ST_UPD:
            begin
                if (st.out_free)
                begin
                    state_next = st.emit_last ? mtpc_pkg::ST_IDLE : mtpc_pkg::ST_MAP;
                end
            end
            default:
            begin
                state_next = mtpc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            mtpc_pkg::ST_CLEAR: cmd.clear_en  = 1'b1;
            mtpc_pkg::ST_IDLE:  cmd.accept_en = 1'b1;
            mtpc_pkg::ST_BUF:   cmd.buf_rd    = 1'b1;
            mtpc_pkg::ST_MAP:   cmd.map_rd    = 1'b1;
            mtpc_pkg::ST_UPD:   cmd.update    = 1'b1;
            default:            cmd           = '0;
        endcase
    end

endmodule

// File: hdl/mtpc_dp.sv
// ---------------------------------------------------------------------------
// mtpc_dp
// Datapath: config registers, range test, corner buffer, point map and
// the output register.
// ---------------------------------------------------------------------------
module mtpc_dp #(
    parameter int MAX_POINTS   = 65536,
    parameter int MAX_CORNERS  = 8,
    parameter int SCALAR_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mtpc_pkg::cmd_t                      cmd,
    output mtpc_pkg::stat_t                     st,
    input  logic                                cfg_we,
    input  logic [mtpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mtpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_opcode,
    input  logic [mtpc_pkg::PID_W-1:0]          in_point_id,
    input  logic [SCALAR_WIDTH-1:0]             in_point_scalar,
    input  logic                                in_point_bad,
    input  logic [SCALAR_WIDTH-1:0]             in_cell_scalar,
    input  logic                                in_cell_bad,
    input  logic                                in_last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                out_kept,
    output logic [mtpc_pkg::PID_W-1:0]          out_cell_index,
    output logic [mtpc_pkg::PID_W-1:0]          out_point,
    output logic [mtpc_pkg::PID_W-1:0]          out_new_index,
    output logic                                out_first,
    output logic                                out_last,
    output logic [mtpc_pkg::ERR_W-1:0]          out_error
);

    localparam int CMPW = (SCALAR_WIDTH > mtpc_pkg::THR_W) ? SCALAR_WIDTH : mtpc_pkg::THR_W;
    localparam int CW   = $clog2(MAX_CORNERS + 1);
    localparam int BAW  = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1;
    localparam int NW   = $clog2(MAX_POINTS + 1);
    localparam int MAW  = $clog2(mtpc_pkg::ID_SPACE);

    logic signed [mtpc_pkg::THR_W-1:0] lower_reg;
    logic signed [mtpc_pkg::THR_W-1:0] upper_reg;
    logic [1:0]                        bmode_reg;
    logic                              on_cells_reg;
    logic                              all_corn_reg;

    logic [CW-1:0]                 count_reg;
    logic                          ovf_reg;
    logic                          ksf_reg;
    logic [NW-1:0]                 nni_reg;
    logic [mtpc_pkg::PID_W-1:0]    kept_cnt_reg;
    logic [mtpc_pkg::PID_W-1:0]    cell_idx_reg;
    logic [CW-1:0]                 k_reg;
    logic [MAW-1:0]                clr_addr_reg;

    logic out_valid_reg;

    logic                          in_fire;
    logic                          corner_fire;
    logic                          has_room;
    logic                          ir_point;
    logic                          ir_cell;
    logic                          ksf_base;
    logic                          ksf_new;
    logic                          ovf_new;
    logic [CW-1:0]                 count_new;
    logic                          reversed;
    logic [mtpc_pkg::ERR_W-1:0]    err_cell;
    logic                          keep;
    logic                          out_free;
    logic                          do_upd;
    logic [CW-1:0]                 k_inc;

    logic [mtpc_pkg::PID_W-1:0]    buf_rdata;
    logic [BAW-1:0]                buf_raddr;
    logic                          buf_re;
    logic                          buf_we;

    logic                          map_we;
    logic [MAW-1:0]                map_waddr;
    logic [mtpc_pkg::MAP_W-1:0]    map_wdata;
    logic [mtpc_pkg::MAP_W-1:0]    map_rdata;
    logic                          map_hit;
    logic                          map_room;
    logic [mtpc_pkg::PID_W-1:0]    new_idx;

    function automatic logic in_range(input logic signed [CMPW-1:0] v, input logic bad,
                                      input logic signed [CMPW-1:0] lo,
                                      input logic signed [CMPW-1:0] hi,
                                      input logic [1:0] mode);
        logic lo_ok;
        logic hi_ok;
        lo_ok = (mode == mtpc_pkg::BND_LOWER || mode == mtpc_pkg::BND_CLOSED) ? (v >= lo)
                                                                              : (v > lo);
        hi_ok = (mode == mtpc_pkg::BND_UPPER || mode == mtpc_pkg::BND_CLOSED) ? (v <= hi)
                                                                              : (v < hi);
        return !bad && lo_ok && hi_ok;
    endfunction

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg    <= '0;
            upper_reg    <= '0;
            bmode_reg    <= mtpc_pkg::BND_CLOSED;
            on_cells_reg <= 1'b1;
            all_corn_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mtpc_pkg::REG_LOWER:    lower_reg    <= cfg_wdata[mtpc_pkg::THR_W-1:0];
                mtpc_pkg::REG_UPPER:    upper_reg    <= cfg_wdata[mtpc_pkg::THR_W-1:0];
                mtpc_pkg::REG_BOUNDARY: bmode_reg    <= cfg_wdata[1:0];
                mtpc_pkg::REG_ON_CELLS: on_cells_reg <= cfg_wdata[0];
                mtpc_pkg::REG_ALL_CORN: all_corn_reg <= cfg_wdata[0];
                default:                ;
            endcase
        end
    end

    assign out_free    = !out_valid_reg || out_ready;
    assign in_ready    = cmd.accept_en && out_free;
    assign in_fire     = in_valid && in_ready;
    assign corner_fire = in_fire && (in_opcode == mtpc_pkg::OP_CORNER);
    assign has_room    = count_reg < CW'(MAX_CORNERS);

    assign ir_point = in_range(CMPW'($signed(in_point_scalar)), in_point_bad,
                               CMPW'(lower_reg), CMPW'(upper_reg), bmode_reg);
    assign ir_cell  = in_range(CMPW'($signed(in_cell_scalar)), in_cell_bad,
                               CMPW'(lower_reg), CMPW'(upper_reg), bmode_reg);

    assign ksf_base  = (count_reg == '0 && !ovf_reg) ? all_corn_reg : ksf_reg;
    assign ksf_new   = !has_room ? ksf_base
                     : (all_corn_reg ? (ksf_base && ir_point) : (ksf_base || ir_point));
    assign ovf_new   = ovf_reg || !has_room;
    assign count_new = has_room ? count_reg + CW'(1) : count_reg;
    assign reversed  = upper_reg < lower_reg;
    assign err_cell  = ovf_new ? mtpc_pkg::ERR_CORNERS
                     : (reversed ? mtpc_pkg::ERR_REVERSED : mtpc_pkg::ERR_NONE);
    assign keep      = (err_cell == mtpc_pkg::ERR_NONE) && (on_cells_reg ? ir_cell : ksf_new);

    assign do_upd = cmd.update && out_free;
    assign k_inc  = k_reg + CW'(1);

    // corner buffer
    assign buf_we    = corner_fire && has_room;
    assign buf_re    = cmd.buf_rd || do_upd;
    assign buf_raddr = cmd.update ? k_inc[BAW-1:0] : '0;

    mtpc_ram #(
        .WIDTH (mtpc_pkg::PID_W),
        .DEPTH (MAX_CORNERS)
    ) u_corner_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (count_reg[BAW-1:0]),
        .wdata (in_point_id),
        .re    (buf_re),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    // point map: valid bit over low index bits
    assign map_hit   = map_rdata[mtpc_pkg::MAP_W-1];
    assign map_room  = nni_reg < NW'(MAX_POINTS);
    assign new_idx   = mtpc_pkg::PID_W'(nni_reg);
    assign map_we    = cmd.clear_en || (do_upd && !map_hit && map_room);
    assign map_waddr = cmd.clear_en ? clr_addr_reg : buf_rdata;
    assign map_wdata = cmd.clear_en ? '0 : {1'b1, new_idx};

    mtpc_ram #(
        .WIDTH (mtpc_pkg::MAP_W),
        .DEPTH (mtpc_pkg::ID_SPACE)
    ) u_point_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (cmd.map_rd),
        .raddr (buf_rdata),
        .rdata (map_rdata)
    );

    // cell and mesh state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            ksf_reg      <= 1'b1;
            nni_reg      <= '0;
            kept_cnt_reg <= '0;
            k_reg        <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cmd.clear_en)
            begin
                clr_addr_reg <= clr_addr_reg + MAW'(1);
            end
            if (in_fire && in_opcode == mtpc_pkg::OP_NEW_MESH)
            begin
                count_reg    <= '0;
                ovf_reg      <= 1'b0;
                ksf_reg      <= 1'b1;
                nni_reg      <= '0;
                kept_cnt_reg <= '0;
                clr_addr_reg <= '0;
            end
            else if (corner_fire)
            begin
                ksf_reg <= ksf_new;
                if (in_last && !keep)
                begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    count_reg <= count_new;
                    ovf_reg   <= ovf_new;
                end
                if (in_last && keep)
                begin
                    k_reg <= '0;
                    if (kept_cnt_reg != '1)
                    begin
                        kept_cnt_reg <= kept_cnt_reg + mtpc_pkg::PID_W'(1);
                    end
                end
            end
            if (do_upd)
            begin
                k_reg <= k_inc;
                if (!map_hit && map_room)
                begin
                    nni_reg <= nni_reg + NW'(1);
                end
                if (st.emit_last)
                begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (corner_fire && in_last && keep)
        begin
            cell_idx_reg <= kept_cnt_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((corner_fire && in_last && !keep) || do_upd)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (corner_fire && in_last && !keep)
        begin
            out_kept       <= 1'b0;
            out_cell_index <= '0;
            out_point      <= '0;
            out_new_index  <= '0;
            out_first      <= 1'b0;
            out_last       <= 1'b1;
            out_error      <= err_cell;
        end
        else if (do_upd)
        begin
            out_kept       <= 1'b1;
            out_cell_index <= cell_idx_reg;
            out_point      <= buf_rdata;
            out_new_index  <= map_hit ? map_rdata[mtpc_pkg::PID_W-1:0]
                                      : (map_room ? new_idx : '0);
            out_first      <= !map_hit && map_room;
            out_last       <= st.emit_last;
            out_error      <= (!map_hit && !map_room) ? mtpc_pkg::ERR_MAP_FULL
                                                      : mtpc_pkg::ERR_NONE;
        end
    end

    assign out_valid = out_valid_reg;

    assign st.clr_done  = clr_addr_reg == '1;
    assign st.clear_req = in_fire && (in_opcode == mtpc_pkg::OP_NEW_MESH);
    assign st.go_emit   = corner_fire && in_last && keep;
    assign st.out_free  = out_free;
    assign st.emit_last = k_inc == count_reg;

endmodule

// File: hdl/mesh_threshold_point_compactor.sv
// ---------------------------------------------------------------------------
// mesh_threshold_point_compactor
// Threshold filter over mesh cells with dense renumbering of used points.
// ---------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_axis    in   tvalid/tready        tdata corner fields, tuser opcode, tlast
//  m_axis    out  tvalid/tready        tdata result fields, tlast last of cell
//  cfg       in   cfg_we               cfg_index, cfg_wdata
//
//  a corner request is taken while idle; a kept cell then reads its corner buffer
//  and steps through each corner in turn (point map read, then write)
//  reset and a new-mesh request sweep the 65536-entry point map, one entry
//  a cycle, with s_axis_tready low
//  a stalled m_axis holds the emit sequence and the intake
// ---------------------------------------------------------------------------
module mesh_threshold_point_compactor #(
    parameter int MAX_POINTS   = 65536,
    parameter int MAX_CORNERS  = 8,
    parameter int SCALAR_WIDTH = 32,
    localparam int IN_BITS  = mtpc_pkg::PID_W + 2 * SCALAR_WIDTH + 2,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = 3 * mtpc_pkg::PID_W + 2 + mtpc_pkg::ERR_W,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mtpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mtpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // point_id, point_scalar, point_scalar_bad, cell_scalar, cell_scalar_bad
    input  logic [IN_W-1:0]                 s_axis_tdata,
    // opcode
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // cell_kept, kept_cell_index, original_point, new_point_index, first_use,
    // error_code
    output logic [OUT_W-1:0]                m_axis_tdata,
    output logic                            m_axis_tlast
);

    localparam int PW = mtpc_pkg::PID_W;
    localparam int SW = SCALAR_WIDTH;

    mtpc_pkg::cmd_t  cmd;
    mtpc_pkg::stat_t st;

    logic          out_kept;
    logic [PW-1:0] out_cell_index;
    logic [PW-1:0] out_point;
    logic [PW-1:0] out_new_index;
    logic          out_first;
    logic [mtpc_pkg::ERR_W-1:0] out_error;

    mtpc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    mtpc_dp #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_CORNERS  (MAX_CORNERS),
        .SCALAR_WIDTH (SCALAR_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .in_opcode       (s_axis_tuser),
        .in_point_id     (s_axis_tdata[PW-1:0]),
        .in_point_scalar (s_axis_tdata[PW+SW-1:PW]),
        .in_point_bad    (s_axis_tdata[PW+SW]),
        .in_cell_scalar  (s_axis_tdata[PW+2*SW:PW+SW+1]),
        .in_cell_bad     (s_axis_tdata[PW+2*SW+1]),
        .in_last         (s_axis_tlast),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_kept        (out_kept),
        .out_cell_index  (out_cell_index),
        .out_point       (out_point),
        .out_new_index   (out_new_index),
        .out_first       (out_first),
        .out_last        (m_axis_tlast),
        .out_error       (out_error)
    );

    assign m_axis_tdata = OUT_W'({out_error, out_first, out_new_index, out_point,
                                  out_cell_index, out_kept});

endmodule

// File: hdl/mtpc_checker.sv
// ---------------------------------------------------------------------------
// mtpc_checker
// Port-level checks of the mesh threshold point compactor.
// ---------------------------------------------------------------------------
module mtpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // rejected cell is a single result with zero payload apart from its error code
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tlast && m_axis_tdata[49:1] == '0)
        else $error("malformed rejected result");

    // kept corner only carries the map full error, never with first use
    a_kept_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |->
            (m_axis_tdata[51:50] == mtpc_pkg::ERR_NONE ||
             m_axis_tdata[51:50] == mtpc_pkg::ERR_MAP_FULL) &&
            !(m_axis_tdata[49] && m_axis_tdata[51:50] != mtpc_pkg::ERR_NONE))
        else $error("bad error code on kept corner");

    // first use of a point means a freshly added map entry
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tdata[49] && m_axis_tdata[0] &&
        !m_axis_tlast
        ##1 m_axis_tvalid && m_axis_tdata[49]
        |-> m_axis_tdata[48:33] != $past(m_axis_tdata[48:33]))
        else $error("first use repeated an index");

endmodule

bind mesh_threshold_point_compactor mtpc_checker u_mtpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
